// File: src/smdc_pkg.sv
// Shared types and constants for the sliding median deviation cost block.
package smdc_pkg;

  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned COST_W    = 40;
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ADDR_W    = 3;
  localparam logic [CFG_W-1:0] LEN_RESET = 9'd3;
  localparam logic [ADDR_W-1:0] ADDR_WINDOW_LEN = 3'd0;

  typedef struct packed {
    logic accept;     // latch sample, read oldest ring slot
    logic remove;     // drop oldest sample from sorted cells
    logic insert;     // insert new sample into sorted cells
    logic scan_clr;   // clear scan counter and accumulator
    logic scan;       // one scan step over cell 0, rotate cells
    logic finish;     // load result register
  } cmd_t;

  typedef struct packed {
    logic full;       // window full before this transaction
    logic will_full;  // window full after the insert
    logic scan_last;  // scan is at the last window entry
  } status_t;

endpackage

// File: src/sliding_median_deviation_cost_top.sv
// Top level of the sliding window median and absolute deviation sum block.
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_stall_o    sample_i
//   out       output     out_valid_o / out_stall_i  median_value_o, cost_o
//   cfg       input      APB psel/penable/pready    paddr, pwdata, prdata
//
// While filling, a sample takes the accept and insert steps. The sample that fills the
// window takes accept, insert, one scan step per window entry through cell 0 of the
// sorted chain, and result load. Once full, a sample takes accept with ring read,
// remove, insert, scan and result load.
// Reset clears control state only; the ring RAM and cells need no clearing.
// A stalled result waits in the output register while the next sample is taken;
// the next result load holds until that result has left.
module sliding_median_deviation_cost_top #(
  parameter int unsigned MAX_WINDOW   = 256,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [smdc_pkg::FIELD_W-1:0]    sample_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [smdc_pkg::FIELD_W-1:0]    median_value_o,
  output logic [smdc_pkg::COST_W-1:0]     cost_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [smdc_pkg::ADDR_W-1:0]     paddr,
  input  logic [smdc_pkg::DATA_W-1:0]     pwdata,
  output logic [smdc_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);

  smdc_pkg::cmd_t             cmd;
  smdc_pkg::status_t          status;
  logic                       cfg_we;
  logic [smdc_pkg::CFG_W-1:0] cfg_len;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == smdc_pkg::ADDR_WINDOW_LEN);
  assign prdata = (paddr == smdc_pkg::ADDR_WINDOW_LEN) ?
                  smdc_pkg::DATA_W'(cfg_len) : '0;

  smdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  smdc_dp #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (pwdata[smdc_pkg::CFG_W-1:0]),
    .cfg_len_o      (cfg_len),
    .sample_i       (sample_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .median_value_o (median_value_o),
    .cost_o         (cost_o)
  );

`ifndef SYNTHESIS
  // after a transaction is taken the block is busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken twice in a row");

  // a new result only appears after the block was busy working on it
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without preceding work");

  // scanning never overlaps a sorted-chain update
  a_scan_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan |-> !(cmd.insert || cmd.remove || cmd.accept))
    else $error("scan overlaps chain update");
`endif

endmodule

// File: src/smdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module smdc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/smdc_ctrl.sv
// Controller state machine: sequences update, scan and result load.
module smdc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  smdc_pkg::status_t status_i,
  output smdc_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_INSERT,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.full ? ST_REMOVE : ST_INSERT;
        end
      end
      ST_REMOVE: begin
        cmd_o.remove = 1'b1;
        state_d      = ST_INSERT;
      end
      ST_INSERT: begin
        cmd_o.insert = 1'b1;
        if (status_i.will_full) begin
          cmd_o.scan_clr = 1'b1;
          state_d        = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: src/smdc_dp.sv
// Datapath: ring RAM, sorted cell chain, scan accumulator, result register.
module smdc_dp #(
  parameter int unsigned MAX_WINDOW   = 256,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [smdc_pkg::CFG_W-1:0]       cfg_wdata_i,
  output logic [smdc_pkg::CFG_W-1:0]       cfg_len_o,
  input  logic [smdc_pkg::FIELD_W-1:0]     sample_i,
  input  smdc_pkg::cmd_t                   cmd_i,
  output smdc_pkg::status_t                status_o,
  output logic [smdc_pkg::FIELD_W-1:0]     median_value_o,
  output logic [smdc_pkg::COST_W-1:0]      cost_o
);

  localparam int unsigned LW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned CW = smdc_pkg::COST_W;

  logic [smdc_pkg::CFG_W-1:0] len_raw_q;
  logic [31:0]                len_full;
  logic [LW-1:0]              len, len_m1, mid, ins_n;
  logic [LW-1:0]              fill_q, k_q;
  logic [AW-1:0]              ptr_q;
  logic [SW-1:0]              x_q, old_val, med_q, med_out_q, head;
  logic [CW-1:0]              acc_q, cost_q;
  logic                       full;

  logic [SW-1:0]         cell_q [MAX_WINDOW];
  logic [SW-1:0]         cell_d [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] ge, gt;

  // clamp length to 1..MAX_WINDOW
  always_comb begin
    if (len_raw_q == '0) begin
      len_full = 32'd1;
    end else if (32'(len_raw_q) > MAX_WINDOW) begin
      len_full = MAX_WINDOW;
    end else begin
      len_full = 32'(len_raw_q);
    end
  end

  assign len    = LW'(len_full);
  assign len_m1 = len - LW'(1);
  assign mid    = len_m1 >> 1;
  assign full   = (fill_q == len);
  assign ins_n  = full ? len_m1 : fill_q;
  assign head   = cell_q[0];

  assign status_o.full      = full;
  assign status_o.will_full = full || ((fill_q + LW'(1)) == len);
  assign status_o.scan_last = (k_q == len_m1);

  smdc_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.remove || (cmd_i.insert && !full)),
    .waddr_i (cmd_i.remove ? ptr_q : fill_q[AW-1:0]),
    .wdata_i (x_q),
    .raddr_i (ptr_q),
    .rdata_o (old_val)
  );

  // sorted cell chain: per-cell compare flags
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      ge[i] = (LW'(i) < len) && (cell_q[i] >= old_val);
      gt[i] = (LW'(i) >= ins_n) || (cell_q[i] > x_q);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      cell_d[i] = cell_q[i];
      if (cmd_i.remove) begin
        if (ge[i] && (i != MAX_WINDOW - 1)) begin
          cell_d[i] = cell_q[i+1];
        end
      end else if (cmd_i.insert) begin
        if (gt[i]) begin
          if ((i != 0) && gt[i-1]) begin
            cell_d[i] = cell_q[i-1];
          end else begin
            cell_d[i] = x_q;
          end
        end
      end else if (cmd_i.scan) begin
        // rotate the window so each entry passes cell 0 once
        if (LW'(i) == len_m1) begin
          cell_d[i] = cell_q[0];
        end else if (i != MAX_WINDOW - 1) begin
          cell_d[i] = cell_q[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      cell_q[i] <= cell_d[i];
    end
    if (cmd_i.accept) begin
      x_q <= sample_i[SW-1:0];
    end
    // cost = upper sum - lower sum, minus median when the length is even
    if (cmd_i.scan_clr) begin
      acc_q <= '0;
    end else if (cmd_i.scan) begin
      if (k_q < mid) begin
        acc_q <= acc_q - CW'(head);
      end else if (k_q == mid) begin
        med_q <= head;
      end else begin
        acc_q <= acc_q + CW'(head);
      end
    end
    if (cmd_i.finish) begin
      med_out_q <= med_q;
      cost_q    <= len[0] ? acc_q : (acc_q - CW'(med_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_raw_q <= smdc_pkg::LEN_RESET;
      fill_q    <= '0;
      ptr_q     <= '0;
      k_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        len_raw_q <= cfg_wdata_i;
        fill_q    <= '0;
        ptr_q     <= '0;
      end else begin
        if (cmd_i.remove) begin
          ptr_q <= ((LW'(ptr_q) + LW'(1)) == len) ? '0 : (ptr_q + AW'(1));
        end
        if (cmd_i.insert && !full) begin
          fill_q <= fill_q + LW'(1);
        end
      end
      if (cmd_i.scan_clr) begin
        k_q <= '0;
      end else if (cmd_i.scan) begin
        k_q <= k_q + LW'(1);
      end
    end
  end

  assign cfg_len_o      = len_raw_q;
  assign median_value_o = smdc_pkg::FIELD_W'(med_out_q);
  assign cost_o         = cost_q;

endmodule

// File: bench/smdc_checker.sv
// Checker: predicts window median and deviation cost and compares every result transaction.
module smdc_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [smdc_pkg::FIELD_W-1:0] sample_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [smdc_pkg::FIELD_W-1:0] median_value_i,
  input  logic [smdc_pkg::COST_W-1:0]  cost_i,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [smdc_pkg::ADDR_W-1:0]  paddr,
  input  logic [smdc_pkg::DATA_W-1:0]  pwdata,
  input  logic                         pready,
  output int unsigned                  errors_o,
  output int unsigned                  pending_o,
  output int unsigned                  results_o
);

  localparam int unsigned MAX_WIN = 256;

  typedef struct packed {
    logic [smdc_pkg::FIELD_W-1:0] median;
    logic [smdc_pkg::COST_W-1:0]  cost;
  } window_stat_t;

  logic [smdc_pkg::FIELD_W-1:0] ring [MAX_WIN];
  logic [smdc_pkg::CFG_W-1:0]   len_reg;
  int unsigned                  held;
  int unsigned                  oldest;
  window_stat_t                 stat_q[$];

  function automatic int unsigned active_len();
    if (len_reg == '0) return 1;
    if (len_reg > MAX_WIN) return MAX_WIN;
    return 32'(len_reg);
  endfunction

  // Sort a copy of the window and sum deviations from the lower median.
  function automatic window_stat_t window_stat(input int unsigned n);
    logic [smdc_pkg::FIELD_W-1:0] srt [MAX_WIN];
    logic [smdc_pkg::FIELD_W-1:0] v;
    logic [63:0]                  acc;
    window_stat_t                 r;
    int                           j;
    for (int i = 0; i < n; i++) begin
      v = ring[i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    r.median = srt[(n - 1) / 2];
    acc = '0;
    for (int i = 0; i < n; i++)
      acc += (srt[i] >= r.median) ? 64'(srt[i] - r.median) : 64'(r.median - srt[i]);
    r.cost = acc[smdc_pkg::COST_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    window_stat_t want;
    int unsigned  n;
    if (!rst_ni) begin
      len_reg   <= smdc_pkg::LEN_RESET;
      held      = 0;
      oldest    = 0;
      errors_o  <= 0;
      results_o <= 0;
      stat_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == smdc_pkg::ADDR_WINDOW_LEN) begin
        len_reg <= pwdata[smdc_pkg::CFG_W-1:0];
        held    = 0;
        oldest  = 0;
      end
      if (in_valid_i && !in_stall_i) begin
        n = active_len();
        if (held < n) begin
          ring[held] = sample_i;
          held++;
          oldest = 0;
          if (held == n) stat_q.push_back(window_stat(n));
        end else begin
          ring[oldest % n] = sample_i;
          oldest = ((oldest % n) + 1 == n) ? 0 : (oldest % n) + 1;
          stat_q.push_back(window_stat(n));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        results_o <= results_o + 1;
        if (stat_q.size() == 0) begin
          errors_o <= errors_o + 1;
          if (errors_o < 10)
            $display("ERROR: unexpected result median=%h cost=%h", median_value_i, cost_i);
        end else begin
          want = stat_q.pop_front();
          if (want.median !== median_value_i || want.cost !== cost_i) begin
            errors_o <= errors_o + 1;
            if (errors_o < 10)
              $display("ERROR: median exp %h got %h, cost exp %h got %h",
                       want.median, median_value_i, want.cost, cost_i);
          end
        end
      end
    end
    pending_o <= stat_q.size();
  end

endmodule

// File: bench/tb.sv
// Testbench top: stimulus, configuration phases, watchdog and verdict.
module tb;

  localparam int unsigned N_ITEMS = 1250;
  localparam int unsigned WD_LIMIT = 20000;
  localparam int unsigned SETTLE = 300;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [smdc_pkg::FIELD_W-1:0]  sample = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [smdc_pkg::FIELD_W-1:0]  median_value;
  logic [smdc_pkg::COST_W-1:0]   cost;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [smdc_pkg::ADDR_W-1:0]   paddr = '0;
  logic [smdc_pkg::DATA_W-1:0]   pwdata = '0;
  logic [smdc_pkg::DATA_W-1:0]   prdata;
  logic                          pready;
  int unsigned                   errors, pending, results;
  int unsigned                   sent = 0;
  int unsigned                   src_idle = 27;
  int unsigned                   dst_idle = 63;
  int unsigned                   quiet = 0;
  int unsigned                   n_cfg = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sliding_median_deviation_cost_top uut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .sample_i(sample),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .median_value_o(median_value), .cost_o(cost),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  smdc_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .sample_i(sample),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .median_value_i(median_value), .cost_i(cost),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  always @(posedge clk_i) out_stall <= ($urandom_range(0, 99) < dst_idle);

  // watchdog: cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WD_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet);
      $display("FAIL sliding_median_deviation_cost_top");
      $finish;
    end
  end

  task automatic send_sample(input logic [smdc_pkg::FIELD_W-1:0] x);
    while ($urandom_range(0, 99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    sample   <= x;
    do @(posedge clk_i); while (in_stall);
    sent++;
    if (sent == N_ITEMS / 3) begin
      src_idle = 63;
      dst_idle = 27;
    end else if (sent == 2 * N_ITEMS / 3) begin
      src_idle = 0;
      dst_idle = 0;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // only while idle: drain, let the block finish, then write
  task automatic write_reg(input logic [smdc_pkg::ADDR_W-1:0] a,
                           input logic [smdc_pkg::DATA_W-1:0] d);
    drain();
    repeat (SETTLE) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    n_cfg++;
  endtask

  function automatic logic [smdc_pkg::FIELD_W-1:0] rand_sample();
    case ($urandom_range(0, 9)) inside
      [0:3]:   return $urandom;
      [4:6]:   return $urandom_range(0, 7);
      7:       return '0;
      8:       return '1;
      default: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
    endcase
  endfunction

  initial begin
    int unsigned len, n, big;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset length of 3, extremes, alternating bits, duplicates
    send_sample('0);
    send_sample('1);
    send_sample(32'hAAAA_AAAA);
    send_sample(32'h5555_5555);
    send_sample('1);
    send_sample('1);
    send_sample('0);
    drain();
    // zero length behaves as one; upper pwdata bits are ignored
    write_reg(smdc_pkg::ADDR_WINDOW_LEN, 32'hFFFF_FE00);
    send_sample('1);
    send_sample(32'd5);
    write_reg(smdc_pkg::ADDR_WINDOW_LEN, 32'd2);
    send_sample('0);
    send_sample('1);
    send_sample('1);
    // length change mid-fill refills from empty
    write_reg(smdc_pkg::ADDR_WINDOW_LEN, 32'd4);
    send_sample(32'd9);
    send_sample(32'd1);
    write_reg(smdc_pkg::ADDR_WINDOW_LEN, 32'd4);
    for (int i = 0; i < 6; i++) send_sample(i[0] ? '1 : '0);
    // write to an unmapped address is ignored
    write_reg(smdc_pkg::ADDR_W'(4), 32'd1);
    send_sample(32'd7);
    send_sample(32'd3);

    // random phases
    big = 0;
    while (sent < N_ITEMS) begin
      if (big == 0) len = 256;
      else if (big == 1) len = 300;
      else if (big == 2) len = 511;
      else len = $urandom_range(0, 20);
      if (len >= 256) big++;
      write_reg(smdc_pkg::ADDR_WINDOW_LEN, ($urandom & ~32'h1FF) | len);
      if (len == 0) len = 1;
      if (len > 256) len = 256;
      n = len + ((len == 256) ? $urandom_range(10, 20) : $urandom_range(5, 60));
      for (int i = 0; i < n; i++) begin
        if (i == n / 2 && $urandom_range(0, 3) == 0) drain();
        send_sample(rand_sample());
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk_i);
    $display("%0d samples sent, %0d results checked, %0d register writes,", sent, results,
             n_cfg);
    $display("window lengths 0..20, 256 and above, with source and sink stalls");
    if (errors == 0 && pending == 0) begin
      $display("PASS sliding_median_deviation_cost_top");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending);
      $display("FAIL sliding_median_deviation_cost_top");
    end
    $finish;
  end

endmodule
